FILE: rtl/core/gatk_pkg.sv
// Shared types and constants for the grouped average top-k block.
package gatk_pkg;

   localparam int unsigned MAX_MOVIES_DEF = 256;
   localparam int unsigned TOP_N_DEF      = 5;

   localparam int unsigned ID_W    = 16;
   localparam int unsigned SCORE_W = 6;
   localparam int unsigned SUM_W   = 22;
   localparam int unsigned CNT_W   = 16;
   localparam int unsigned RANK_W  = 3;
   localparam int unsigned AVG_W   = 9;
   localparam int unsigned NUM_W   = 27;
   localparam int unsigned DEN_W   = 17;

   localparam logic [SCORE_W-1:0] SCORE_MAX = SCORE_W'(50);
   localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};

   localparam logic ACT_ADD    = 1'b0;
   localparam logic ACT_REPORT = 1'b1;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [SUM_W-1:0] sum;
      logic [CNT_W-1:0] cnt;
   } gatk_rec_type;

   typedef struct packed {
      logic         vld;
      gatk_rec_type rec;
   } gatk_ent_type;

endpackage

FILE: rtl/core/gatk_cell.sv
// One insertion cell of the ranking chain: keeps the best entry seen, passes the other on.
module gatk_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  clear,
   input  gatk_pkg::gatk_ent_type in_ent,
   output gatk_pkg::gatk_ent_type held,
   output gatk_pkg::gatk_ent_type pass
);
   import gatk_pkg::*;

   gatk_ent_type held_ff, held_in;
   gatk_ent_type pass_ff, pass_in;
   logic [SUM_W+CNT_W-1:0] lhs, rhs;
   logic                   in_first;

   assign lhs = in_ent.rec.sum * held_ff.rec.cnt;
   assign rhs = held_ff.rec.sum * in_ent.rec.cnt;
   assign in_first = (lhs != rhs) ? (lhs > rhs) : (in_ent.rec.id < held_ff.rec.id);

   always_comb begin
      held_in = held_ff;
      pass_in = in_ent;
      if (in_ent.vld) begin
         if (!held_ff.vld) begin
            held_in     = in_ent;
            pass_in.vld = 1'b0;
         end else if (in_first) begin
            held_in = in_ent;
            pass_in = held_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         held_ff.vld <= 1'b0;
         pass_ff.vld <= 1'b0;
      end else begin
         held_ff.vld <= held_in.vld;
         pass_ff.vld <= pass_in.vld;
      end
      held_ff.rec <= held_in.rec;
      pass_ff.rec <= pass_in.rec;
   end

   assign held = held_ff;
   assign pass = pass_ff;
endmodule

FILE: rtl/core/gatk_div.sv
// Restoring divider, one quotient bit per cycle.
module gatk_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [gatk_pkg::NUM_W-1:0] num,
   input  logic [gatk_pkg::DEN_W-1:0] den,
   output logic                       done,
   output logic [gatk_pkg::NUM_W-1:0] quo
);
   import gatk_pkg::*;

   localparam int unsigned SW = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [SW-1:0]    cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [NUM_W-1:0] q_ff, q_in;
   logic [DEN_W:0]   trial;
   logic             take;

   assign trial = {rem_ff, q_ff[NUM_W-1]};
   assign take  = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         den_in  = den;
         q_in    = num;
      end else if (busy_ff) begin
         rem_in = take ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         q_in   = {q_ff[NUM_W-2:0], take};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == SW'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
   end

   assign done = done_ff;
   assign quo  = q_ff;
endmodule

FILE: rtl/core/grouped_average_top_k.sv
// Top level of the grouped average top-k block: rating table, ranking chain and result path.
// An add beat searches the table one entry per cycle; the read port of the table memory is
// registered. A report beat streams every entry through a chain of TOP_N ranking cells,
// then forms the rounded average of each result in the shared bit-serial divider and waits
// for the result beat to be taken. One beat is in work at a time; the table needs no
// clearing pass after reset.
module grouped_average_top_k #(
   parameter int unsigned MAX_MOVIES = gatk_pkg::MAX_MOVIES_DEF,
   parameter int unsigned TOP_N      = gatk_pkg::TOP_N_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // movie_id, score, zero pad
   input  logic [0:0]  req_tuser,  // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // rank, top_movie, average_hundredths, votes, overflow_seen, pad
   output logic [0:0]  rsp_tuser,  // empty_res
   output logic        rsp_tlast
);
   import gatk_pkg::*;

   localparam int unsigned AW = (MAX_MOVIES > 1) ? $clog2(MAX_MOVIES) : 1;
   localparam int unsigned CW = $clog2(MAX_MOVIES + 1);
   localparam int unsigned NW = $clog2(TOP_N + 1);
   localparam int unsigned RW = (TOP_N > 1) ? $clog2(TOP_N) : 1;
   localparam int unsigned DW = $clog2(TOP_N + 2);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SRCH = 3'd1;
   localparam logic [2:0] ST_WALK = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_DIVW = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;

   logic [2:0]         state_ff, state_in;
   logic [CW-1:0]      used_ff, used_in;
   logic               drop_ff, drop_in;
   logic [CW-1:0]      ptr_ff, ptr_in;
   logic               chk_ff, chk_in;
   logic [AW-1:0]      chk_addr_ff;
   logic               feed_ff, feed_in;
   logic [DW-1:0]      drain_ff, drain_in;
   logic [NW-1:0]      r_ff, r_in;
   logic [ID_W-1:0]    id_ff, id_in;
   logic [SCORE_W-1:0] score_ff, score_in;
   logic               clear_cells;

   gatk_rec_type       mem [MAX_MOVIES];
   gatk_rec_type       rd_ff;
   logic               we;
   logic [AW-1:0]      wr_addr;
   gatk_rec_type       wr_rec;

   logic               vld_ff, vld_in;
   logic [RANK_W-1:0]  rank_ff, rank_in;
   logic [ID_W-1:0]    mov_ff, mov_in;
   logic [AVG_W-1:0]   avg_ff, avg_in;
   logic [CNT_W-1:0]   votes_ff, votes_in;
   logic               empty_ff, empty_in;
   logic               last_ff, last_in;

   gatk_ent_type       link [TOP_N+1];
   gatk_ent_type       held [TOP_N];
   gatk_ent_type       sel;
   logic [CW+NW-1:0]   used_ext;
   logic [NW-1:0]      n_res;
   logic               div_start, div_done;
   logic [NUM_W-1:0]   div_num, div_quo;
   logic [SCORE_W-1:0] req_score;
   logic               hit, miss, more;

   assign used_ext  = (CW+NW)'(used_ff);
   assign n_res     = (used_ff >= CW'(TOP_N)) ? NW'(TOP_N) : used_ext[NW-1:0];
   assign more      = ptr_ff < used_ff;
   assign hit       = (state_ff == ST_SRCH) && chk_ff && (rd_ff.id == id_ff);
   assign miss      = (state_ff == ST_SRCH) && !chk_ff && !more;
   assign req_score = (req_tdata[21:16] > SCORE_MAX) ? SCORE_MAX : req_tdata[21:16];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wr_addr] <= wr_rec;
      end
      rd_ff <= mem[ptr_ff[AW-1:0]];
   end

   assign link[0] = '{vld: feed_ff, rec: rd_ff};

   for (genvar g = 0; g < TOP_N; g++) begin : g_cell
      gatk_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .clear  (clear_cells),
         .in_ent (link[g]),
         .held   (held[g]),
         .pass   (link[g+1])
      );
   end

   assign sel     = held[r_ff[RW-1:0]];
   assign div_num = (NUM_W'(sel.rec.sum) << 4) + (NUM_W'(sel.rec.sum) << 2)
                  + NUM_W'(sel.rec.cnt);

   gatk_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   ({sel.rec.cnt, 1'b0}),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_comb begin
      state_in    = state_ff;
      used_in     = used_ff;
      drop_in     = drop_ff;
      ptr_in      = ptr_ff;
      chk_in      = 1'b0;
      feed_in     = 1'b0;
      drain_in    = drain_ff;
      r_in        = r_ff;
      id_in       = id_ff;
      score_in    = score_ff;
      clear_cells = 1'b0;
      we          = 1'b0;
      wr_addr     = chk_addr_ff;
      wr_rec      = rd_ff;
      div_start   = 1'b0;
      vld_in      = vld_ff;
      rank_in     = rank_ff;
      mov_in      = mov_ff;
      avg_in      = avg_ff;
      votes_in    = votes_ff;
      empty_in    = empty_ff;
      last_in     = last_ff;
      req_tready  = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               id_in    = req_tdata[15:0];
               score_in = req_score;
               ptr_in   = '0;
               if (req_tuser[0] == ACT_ADD) begin
                  state_in = ST_SRCH;
               end else if (used_ff == '0) begin
                  vld_in   = 1'b1;
                  rank_in  = '0;
                  mov_in   = '0;
                  avg_in   = '0;
                  votes_in = '0;
                  empty_in = 1'b1;
                  last_in  = 1'b1;
                  state_in = ST_OUT;
               end else begin
                  clear_cells = 1'b1;
                  drain_in    = '0;
                  state_in    = ST_WALK;
               end
            end
         end
         ST_SRCH: begin
            chk_in = more;
            if (more) begin
               ptr_in = ptr_ff + 1'b1;
            end
            if (hit) begin
               state_in = ST_IDLE;
               if (rd_ff.cnt == CNT_MAX) begin
                  drop_in = 1'b1;
               end else begin
                  we     = 1'b1;
                  wr_rec = '{id: id_ff, sum: rd_ff.sum + SUM_W'(score_ff),
                             cnt: rd_ff.cnt + 1'b1};
               end
            end else if (miss) begin
               state_in = ST_IDLE;
               if (used_ff == CW'(MAX_MOVIES)) begin
                  drop_in = 1'b1;
               end else begin
                  we      = 1'b1;
                  wr_addr = used_ff[AW-1:0];
                  wr_rec  = '{id: id_ff, sum: SUM_W'(score_ff), cnt: CNT_W'(1)};
                  used_in = used_ff + 1'b1;
               end
            end
         end
         ST_WALK: begin
            if (more) begin
               feed_in = 1'b1;
               ptr_in  = ptr_ff + 1'b1;
            end else begin
               drain_in = drain_ff + 1'b1;
               if (drain_ff == DW'(TOP_N + 1)) begin
                  r_in     = '0;
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            div_start = 1'b1;
            state_in  = ST_DIVW;
         end
         ST_DIVW: begin
            if (div_done) begin
               vld_in   = 1'b1;
               rank_in  = RANK_W'(r_ff + 1'b1);
               mov_in   = sel.rec.id;
               avg_in   = div_quo[AVG_W-1:0];
               votes_in = sel.rec.cnt;
               empty_in = 1'b0;
               last_in  = (NW'(r_ff + 1'b1) == n_res);
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_tready) begin
               vld_in   = 1'b0;
               r_in     = r_ff + 1'b1;
               state_in = last_ff ? ST_IDLE : ST_DIV;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         used_ff  <= '0;
         drop_ff  <= 1'b0;
         chk_ff   <= 1'b0;
         feed_ff  <= 1'b0;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         drop_ff  <= drop_in;
         chk_ff   <= chk_in;
         feed_ff  <= feed_in;
         vld_ff   <= vld_in;
      end
      chk_addr_ff <= ptr_ff[AW-1:0];
      ptr_ff      <= ptr_in;
      drain_ff    <= drain_in;
      r_ff        <= r_in;
      id_ff       <= id_in;
      score_ff    <= score_in;
      rank_ff     <= rank_in;
      mov_ff      <= mov_in;
      avg_ff      <= avg_in;
      votes_ff    <= votes_in;
      empty_ff    <= empty_in;
      last_ff     <= last_in;
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = {3'b000, drop_ff, votes_ff, avg_ff, mov_ff, rank_ff};
   assign rsp_tuser  = empty_ff;
   assign rsp_tlast  = last_ff;

`ifndef SYNTHESIS
   a_busy_no_req: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("input taken while a result waits");
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CW'(MAX_MOVIES)) else $error("table fill beyond depth");
   a_drop_sticky: assert property (@(posedge clock) disable iff (reset)
      drop_ff |=> drop_ff) else $error("overflow flag cleared");
   a_hit_miss: assert property (@(posedge clock) disable iff (reset)
      !(hit && miss)) else $error("search both hit and missed");
`endif
endmodule
